@@ src/rqr_pkg.sv @@
// shared types, constants and helper functions of the ready queue
package rqr_pkg;

   localparam int DEPTH    = 16;
   localparam int ID_WIDTH = 16;
   localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int MODE_W   = 2;
   localparam int STAT_W   = 2;
   localparam int FID_W    = 16;
   localparam int OCC_W    = 5;

   localparam logic [MODE_W-1:0] MODE_ENQ = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DEQ = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REM = 2'd2;

   localparam logic [STAT_W-1:0] STATUS_DONE = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_MISS = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [FID_W-1:0]  tid;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [FID_W-1:0]  result_id;
      logic [OCC_W-1:0]  occupancy;
   } rsp_type;

   typedef struct packed {
      logic                we;
      logic [IDX_W-1:0]    waddr;
      logic [ID_WIDTH-1:0] wdata;
      logic                re;
      logic [IDX_W-1:0]    raddr;
   } mem_req_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_DEQ_WAIT,
      S_SCAN,
      S_SHIFT,
      S_DONE
   } state_type;

   // physical slot of the entry at a given distance from the head
   function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] head,
                                             input logic [IDX_W-1:0] off);
      logic [IDX_W:0] sum;
      sum = {1'b0, head} + {1'b0, off};
      if (sum >= (IDX_W+1)'(DEPTH)) begin
         sum = sum - (IDX_W+1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   function automatic logic [ID_WIDTH-1:0] id_from_field(input logic [FID_W-1:0] f);
      logic [63:0] w;
      w = 64'(f);
      return w[ID_WIDTH-1:0];
   endfunction

   function automatic logic [FID_W-1:0] id_to_field(input logic [ID_WIDTH-1:0] v);
      logic [63:0] w;
      w = 64'(v);
      return w[FID_W-1:0];
   endfunction

   function automatic logic [OCC_W-1:0] count_to_occ(input logic [CNT_W-1:0] c);
      logic [63:0] w;
      w = 64'(c);
      return w[OCC_W-1:0];
   endfunction

endpackage

@@ src/ready_queue_with_remove_by_id.sv @@
// top level of the ordered thread id queue with remove by id
//
// req channel: one transaction carries mode (enqueue, dequeue head, remove first
// matching id) and tid. rsp channel: exactly one transaction per request,
// in request order, with status, result_id and the occupancy after the operation.
// both channels use valid/stall; a transaction moves when valid is high and stall low.
// the ids live in a DEPTH-entry memory with registered read data; the head
// index and the entry count sit in flip-flops in the sequencer.
// enqueue writes one entry, dequeue reads the head entry, and remove scans from the head
// with one memory read per entry scanned and one read plus write per entry moved
// during compaction. one request is worked on at a time: a new one is taken only
// while the sequencer is idle or hands its result to the output register.
// the response sits in an output register; while the receiver stalls, the
// next request is still taken and worked on, and its result waits in the
// sequencer until the register frees up.
// reset empties the queue at once; memory contents are left as they are.
module ready_queue_with_remove_by_id
   import rqr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp
);

   logic                rsp_valid_ff;
   rsp_type             rsp_ff;
   logic                out_free;
   logic                done_valid;
   rsp_type             done_rsp;
   mem_req_type         mem_req;
   logic [ID_WIDTH-1:0] mem_rdata;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   rqr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req        (req),
      .req_stall  (req_stall),
      .out_free   (out_free),
      .done_valid (done_valid),
      .done_rsp   (done_rsp),
      .mem_req    (mem_req),
      .mem_rdata  (mem_rdata)
   );

   rqr_ram #(
      .DEPTH_P (DEPTH),
      .WIDTH_P (ID_WIDTH)
   ) u_ram (
      .clock (clock),
      .we    (mem_req.we),
      .waddr (mem_req.waddr),
      .wdata (mem_req.wdata),
      .re    (mem_req.re),
      .raddr (mem_req.raddr),
      .rdata (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done_valid && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done_valid && out_free) begin
         rsp_ff <= done_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

@@ src/rqr_ram.sv @@
// generic single-write single-read memory with registered read data
module rqr_ram #(
   parameter int DEPTH_P = 16,
   parameter int WIDTH_P = 16,
   parameter int ADDR_W_P = (DEPTH_P > 1) ? $clog2(DEPTH_P) : 1
) (
   input  logic                clock,
   input  logic                we,
   input  logic [ADDR_W_P-1:0] waddr,
   input  logic [WIDTH_P-1:0]  wdata,
   input  logic                re,
   input  logic [ADDR_W_P-1:0] raddr,
   output logic [WIDTH_P-1:0]  rdata
);

   logic [WIDTH_P-1:0] mem_ff [DEPTH_P];
   logic [WIDTH_P-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ src/rqr_ctrl.sv @@
// operation sequencer: head and count, scan and compaction over the entry memory
module rqr_ctrl
   import rqr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  req_type             req,
   output logic                req_stall,
   input  logic                out_free,
   output logic                done_valid,
   output rsp_type             done_rsp,
   output mem_req_type         mem_req,
   input  logic [ID_WIDTH-1:0] mem_rdata
);

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [ID_WIDTH-1:0] id_ff, id_in;
   logic [STAT_W-1:0]   status_ff, status_in;
   logic [ID_WIDTH-1:0] got_ff, got_in;
   logic                accept;
   logic                is_match;
   logic                more_scan;
   logic                more_shift;

   assign req_stall  = !((state_ff == S_IDLE) || ((state_ff == S_DONE) && out_free));
   assign accept     = req_valid && !req_stall;
   assign is_match   = (mem_rdata == id_ff);
   assign more_scan  = ((CNT_W'(idx_ff) + CNT_W'(1)) < count_ff);
   assign more_shift = ((CNT_W'(idx_ff) + CNT_W'(2)) < count_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_START;
            end
         end
         S_START: begin
            case (mode_ff)
               MODE_ENQ: state_in = S_DONE;
               MODE_DEQ: state_in = (count_ff == '0) ? S_DONE : S_DEQ_WAIT;
               MODE_REM: state_in = (count_ff == '0) ? S_DONE : S_SCAN;
               default:  state_in = S_DONE;
            endcase
         end
         S_DEQ_WAIT: state_in = S_DONE;
         S_SCAN: begin
            if (is_match && more_scan) begin
               state_in = S_SHIFT;
            end else if (is_match || !more_scan) begin
               state_in = S_DONE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SHIFT: state_in = more_shift ? S_SHIFT : S_DONE;
         S_DONE: begin
            if (out_free) begin
               state_in = accept ? S_START : S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      head_in    = head_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      mode_in    = mode_ff;
      id_in      = id_ff;
      status_in  = status_ff;
      got_in     = got_ff;
      mem_req    = '0;
      done_valid = 1'b0;
      done_rsp   = '{status: status_ff, result_id: id_to_field(got_ff),
                     occupancy: count_to_occ(count_ff)};
      if (accept) begin
         mode_in   = req.mode;
         id_in     = id_from_field(req.tid);
         status_in = STATUS_MISS;
         got_in    = '0;
      end
      case (state_ff)
         S_START: begin
            case (mode_ff)
               MODE_ENQ: begin
                  if (count_ff == CNT_W'(DEPTH)) begin
                     status_in = STATUS_FULL;
                  end else begin
                     mem_req.we    = 1'b1;
                     mem_req.waddr = slot(head_ff, count_ff[IDX_W-1:0]);
                     mem_req.wdata = id_ff;
                     count_in      = count_ff + CNT_W'(1);
                     status_in     = STATUS_DONE;
                  end
               end
               MODE_DEQ, MODE_REM: begin
                  mem_req.re    = (count_ff != '0);
                  mem_req.raddr = head_ff;
                  idx_in        = '0;
               end
               default: status_in = STATUS_MISS;
            endcase
         end
         S_DEQ_WAIT: begin
            got_in    = mem_rdata;
            head_in   = slot(head_ff, IDX_W'(1));
            count_in  = count_ff - CNT_W'(1);
            status_in = STATUS_DONE;
         end
         S_SCAN: begin
            if (is_match) begin
               got_in    = mem_rdata;
               status_in = STATUS_DONE;
               if (more_scan) begin
                  mem_req.re    = 1'b1;
                  mem_req.raddr = slot(head_ff, idx_ff + IDX_W'(1));
               end else begin
                  count_in = count_ff - CNT_W'(1);
               end
            end else if (more_scan) begin
               mem_req.re    = 1'b1;
               mem_req.raddr = slot(head_ff, idx_ff + IDX_W'(1));
               idx_in        = idx_ff + IDX_W'(1);
            end
         end
         S_SHIFT: begin
            // move the entry behind the gap one place toward the head
            mem_req.we    = 1'b1;
            mem_req.waddr = slot(head_ff, idx_ff);
            mem_req.wdata = mem_rdata;
            if (more_shift) begin
               mem_req.re    = 1'b1;
               mem_req.raddr = slot(head_ff, idx_ff + IDX_W'(2));
               idx_in        = idx_ff + IDX_W'(1);
            end else begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         S_DONE: done_valid = 1'b1;
         default: done_valid = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      mode_ff   <= mode_in;
      id_ff     <= id_in;
      status_ff <= status_in;
      got_ff    <= got_in;
   end

endmodule

@@ src/rqr_checker.sv @@
// port-level checker for the ready queue, bound to the top level
module rqr_checker
   import rqr_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input req_type req,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("rsp transaction changed while stalled");

   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.status == STATUS_FULL) |-> rsp.occupancy == count_to_occ(CNT_W'(DEPTH)))
      else $error("full status with queue not full");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.status != STATUS_DONE) |-> rsp.result_id == '0)
      else $error("nonzero result_id on a failed operation");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.status == STATUS_DONE) || (rsp.status == STATUS_MISS) ||
                    (rsp.status == STATUS_FULL))
      else $error("undefined status code");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while the previous one is in progress");

endmodule

bind ready_queue_with_remove_by_id rqr_checker u_rqr_checker (.*);
